@@ rtl/lfu_cache_table_assert.svh @@
// assertion macros for the lfu cache table checker
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// same-cycle implication
`define LCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define LCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/lfu_ct_pkg.sv @@
// shared types and constants of the lfu cache table
package lfu_ct_pkg;

    localparam int CAP_DEFAULT        = 16;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CAPACITY_W         = 5;
    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } res_t;

endpackage

@@ rtl/lfu_ct_store.sv @@
// entry memory with one write port and a registered read port
module lfu_ct_store #(
    parameter int DEPTH  = lfu_ct_pkg::CAP_DEFAULT,
    parameter int DATA_W = 64,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lfu_ct_ctrl.sv @@
// sequencer: match/victim scan and count/rank update pass over the entry memory
module lfu_ct_ctrl #(
    parameter int CAP        = lfu_ct_pkg::CAP_DEFAULT,
    parameter int COUNT_BITS = lfu_ct_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [lfu_ct_pkg::CAPACITY_W-1:0]   capacity,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    input  logic [lfu_ct_pkg::KEY_W-1:0]        in_key,
    input  logic [lfu_ct_pkg::VAL_W-1:0]        in_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output lfu_ct_pkg::res_t                    res
);

    localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > lfu_ct_pkg::CAPACITY_W) ? CNT_W : lfu_ct_pkg::CAPACITY_W;
    localparam int KW     = lfu_ct_pkg::KEY_W;
    localparam int VW     = lfu_ct_pkg::VAL_W;
    localparam int ENT_W  = KW + VW + COUNT_BITS + RANK_W;

    typedef struct packed {
        logic [KW-1:0]         key;
        logic [VW-1:0]         value;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_W-1:0]     rank;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPD    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic            op_reg, op_next;
    logic [KW-1:0]   key_reg, key_next;
    logic [VW-1:0]   val_reg, val_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic            found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [RANK_W-1:0] mrank_reg, mrank_next;
    logic [VW-1:0]   mval_reg, mval_next;
    logic            have_reg, have_next;
    logic [IDX_W-1:0] vic_reg, vic_next;
    logic [COUNT_BITS-1:0] vcnt_reg, vcnt_next;
    logic [RANK_W-1:0] vrank_reg, vrank_next;
    logic [KW-1:0]   vkey_reg, vkey_next;
    logic            ffound_reg, ffound_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic            ins_reg, ins_next;
    logic            evict_reg, evict_next;
    logic [IDX_W-1:0] tslot_reg, tslot_next;
    logic [CAP-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    lfu_ct_pkg::res_t res_reg, res_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_ent;
    entry_t            rd_ent;
    logic [CMP_W-1:0]  cap_ext, cap_lim, cap_eff, occ_ext;
    logic              ev;
    logic [IDX_W-1:0]  ins_slot;
    logic              ins;

    lfu_ct_store #(
        .DEPTH  (CAP),
        .DATA_W (ENT_W),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent)
    );

    assign rd_ent  = entry_t'(rd_data);
    assign cap_ext = CMP_W'(capacity);
    assign cap_lim = CMP_W'(CAP);
    assign cap_eff = (cap_ext > cap_lim) ? cap_lim : cap_ext;
    assign occ_ext = CMP_W'(occ_reg);
    assign ev       = (occ_ext >= cap_eff) && (occ_reg != '0) && have_reg;
    assign ins_slot = ev ? ((ffound_reg && (free_reg < vic_reg)) ? free_reg : vic_reg)
                         : free_reg;
    assign ins      = ev || ffound_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign rd_addr   = idx_reg[IDX_W-1:0];

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        mrank_next  = mrank_reg;
        mval_next   = mval_reg;
        have_next   = have_reg;
        vic_next    = vic_reg;
        vcnt_next   = vcnt_reg;
        vrank_next  = vrank_reg;
        vkey_next   = vkey_reg;
        ffound_next = ffound_reg;
        free_next   = free_reg;
        ins_next    = ins_reg;
        evict_next  = evict_reg;
        tslot_next  = tslot_reg;
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        res_next    = res_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pidx_reg;
        wr_ent      = rd_ent;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    key_next    = in_key;
                    val_next    = in_value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    have_next   = 1'b0;
                    ffound_next = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg != CNT_W'(CAP)) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = S_DECIDE;
                end
                if (pend_reg) begin
                    if (valid_reg[pidx_reg] && (rd_ent.key == key_reg) && !found_reg) begin
                        found_next = 1'b1;
                        slot_next  = pidx_reg;
                        mrank_next = rd_ent.rank;
                        mval_next  = rd_ent.value;
                    end
                    if (!valid_reg[pidx_reg] && !ffound_reg) begin
                        ffound_next = 1'b1;
                        free_next   = pidx_reg;
                    end
                    if (valid_reg[pidx_reg] && (!have_reg || (rd_ent.count < vcnt_reg) ||
                        ((rd_ent.count == vcnt_reg) && (rd_ent.rank > vrank_reg)))) begin
                        have_next  = 1'b1;
                        vic_next   = pidx_reg;
                        vcnt_next  = rd_ent.count;
                        vrank_next = rd_ent.rank;
                        vkey_next  = rd_ent.key;
                    end
                end
            end
            S_DECIDE: begin
                res_next   = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
                idx_next   = '0;
                ins_next   = 1'b0;
                evict_next = 1'b0;
                tslot_next = slot_reg;
                state_next = S_DONE;
                if (op_reg == lfu_ct_pkg::OP_GET) begin
                    if (found_reg) begin
                        res_next.hit        = 1'b1;
                        res_next.read_value = mval_reg;
                        state_next          = S_UPD;
                    end
                end else if (cap_eff != '0) begin
                    if (found_reg) begin
                        res_next.hit = 1'b1;
                        state_next   = S_UPD;
                    end else begin
                        evict_next = ev;
                        ins_next   = 1'b1;
                        tslot_next = ins_slot;
                        if (ev) begin
                            res_next.evicted     = 1'b1;
                            res_next.evicted_key = vkey_reg;
                            valid_next[vic_reg]  = 1'b0;
                        end
                        if (ins) begin
                            valid_next[ins_slot] = 1'b1;
                            state_next           = S_UPD;
                        end
                        if (ev && !ins) begin
                            occ_next = occ_reg - 1'b1;
                        end else if (!ev && ins) begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                end
            end
            S_UPD: begin
                if (idx_reg != CNT_W'(CAP)) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = S_DONE;
                end
                if (pend_reg) begin
                    if (pidx_reg == tslot_reg) begin
                        wr_en       = 1'b1;
                        wr_ent.rank = '0;
                        if (ins_reg) begin
                            wr_ent.key   = key_reg;
                            wr_ent.value = val_reg;
                            wr_ent.count = COUNT_BITS'(1);
                        end else begin
                            if (op_reg == lfu_ct_pkg::OP_PUT) begin
                                wr_ent.value = val_reg;
                            end
                            if (rd_ent.count != '1) begin
                                wr_ent.count = rd_ent.count + 1'b1;
                            end
                        end
                    end else if (valid_reg[pidx_reg]) begin
                        wr_en = 1'b1;
                        if (ins_reg) begin
                            if (!(evict_reg && (rd_ent.rank > vrank_reg))) begin
                                wr_ent.rank = rd_ent.rank + 1'b1;
                            end
                        end else if (rd_ent.rank < mrank_reg) begin
                            wr_ent.rank = rd_ent.rank + 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        mrank_reg  <= mrank_next;
        mval_reg   <= mval_next;
        have_reg   <= have_next;
        vic_reg    <= vic_next;
        vcnt_reg   <= vcnt_next;
        vrank_reg  <= vrank_next;
        vkey_reg   <= vkey_next;
        ffound_reg <= ffound_next;
        free_reg   <= free_next;
        ins_reg    <= ins_next;
        evict_reg  <= evict_next;
        tslot_reg  <= tslot_next;
        res_reg    <= res_next;
    end

endmodule

@@ rtl/lfu_cache_table.sv @@
// lfu cache table top level: capacity register, sequencer and output register
//
// Fully associative key/value store with least-frequently-used replacement,
// ties broken toward the least recently used entry.
// Input stream: s_tuser carries the operation (0 get, 1 put), s_tdata the key
// and value. Result stream: m_tuser carries hit and evicted, m_tdata the read
// value (-1 on a miss or a put) and the evicted key (0 when nothing left).
// The capacity register is written through cfg_valid/cfg_ready/cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce, and writes are always taken. Each transaction scans all CAP entries
// through the registered memory port, decides, then rewrites use counts and
// recency ranks in a second pass over all entries. s_tready returns in the same
// cycle that the result reaches m_tvalid, so a new item is taken only once the
// previous result has moved to the output register. A get miss or an ignored
// put skips the second pass.
// A stalled receiver holds the next result in the sequencer and keeps s_tready
// low until the output register frees up.
// Reset clears all entries and sets capacity to 16; no clearing pass is needed.
module lfu_cache_table #(
    parameter int CAP        = lfu_ct_pkg::CAP_DEFAULT,
    parameter int COUNT_BITS = lfu_ct_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,    // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // key [31:0], value [63:32]
    input  logic [0:0]  s_tuser,     // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // read_value [31:0], evicted_key [63:32]
    output logic [1:0]  m_tuser      // hit [0], evicted [1]
);

    logic [lfu_ct_pkg::CAPACITY_W-1:0] capacity_reg;
    logic                              m_tvalid_reg;
    lfu_ct_pkg::res_t                  out_reg;
    lfu_ct_pkg::res_t                  res;
    logic                              res_valid;
    logic                              res_ready;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lfu_ct_pkg::CAPACITY_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    lfu_ct_ctrl #(
        .CAP        (CAP),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (capacity_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.evicted_key, out_reg.read_value};
    assign m_tuser  = {out_reg.evicted, out_reg.hit};

endmodule

@@ rtl/lfu_ct_checker.sv @@
// port-level checker for the lfu cache table and its bind
`include "lfu_cache_table_assert.svh"

module lfu_ct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `LCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LCT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LCT_ASSERT_IMPL(a_evict_no_hit, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0])
    `LCT_ASSERT_IMPL(a_miss_value, aclk, aresetn, m_tvalid && !m_tuser[0],
                     m_tdata[31:0] == 32'hFFFF_FFFF)
    `LCT_ASSERT_IMPL(a_no_evict_key, aclk, aresetn, m_tvalid && !m_tuser[1],
                     m_tdata[63:32] == 32'h0)

endmodule

bind lfu_cache_table lfu_ct_checker u_lfu_ct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb_lfu_cache_table.sv @@
// testbench for lfu_cache_table: random and directed gets and puts checked against a predictor
module tb_lfu_cache_table;

    localparam int NCAP = 16;
    localparam int CNT_MAX = 65535;
    localparam int LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;  // key, value
    logic [0:0]  s_tuser = '0;  // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;       // read_value, evicted_key
    logic [1:0]  m_tuser;       // hit, evicted

    lfu_cache_table i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] val;
        logic        is_cfg;
        logic [4:0]  cap;
        logic        drain;
    } txn_t;

    txn_t              pending_q[$];
    lfu_ct_pkg::res_t  expected_q[$];
    int     errors = 0;
    int     cycles = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_cycles = 0;
    logic   stall_req = 1'b0;
    logic   stall_started = 1'b0;

    // predictor state
    logic [4:0]  cap_r = lfu_ct_pkg::CAPACITY_RESET;
    logic        pv[NCAP] = '{default: 1'b0};
    logic [31:0] pk[NCAP] = '{default: 32'h0};
    logic [31:0] pval[NCAP] = '{default: 32'h0};
    int          pcnt[NCAP] = '{default: 0};
    int          prank[NCAP] = '{default: 0};
    int          pocc = 0;

    logic [31:0] keys_used[$];

    function automatic void touch_entry(int s);
        if (pcnt[s] < CNT_MAX) pcnt[s]++;
        for (int i = 0; i < NCAP; i++)
            if (pv[i] && prank[i] < prank[s]) prank[i]++;
        prank[s] = 0;
    endfunction

    function automatic lfu_ct_pkg::res_t predict_access(logic op, logic [31:0] key,
                                                         logic [31:0] val);
        lfu_ct_pkg::res_t r;
        int slot, cap, v, fr;
        bit found, have;
        r = '{hit: 1'b0, read_value: 32'hFFFF_FFFF, evicted: 1'b0, evicted_key: '0};
        cap = (cap_r > NCAP) ? NCAP : int'(cap_r);
        found = 0; slot = 0;
        for (int i = 0; i < NCAP; i++)
            if (!found && pv[i] && pk[i] == key) begin
                found = 1; slot = i;
            end
        if (op == lfu_ct_pkg::OP_GET) begin
            if (found) begin
                r.hit = 1'b1;
                touch_entry(slot);
                r.read_value = pval[slot];
            end
        end else if (cap != 0) begin
            if (found) begin
                r.hit = 1'b1;
                pval[slot] = val;
                touch_entry(slot);
            end else begin
                if (pocc >= cap && pocc != 0) begin
                    have = 0; v = 0;
                    for (int i = 0; i < NCAP; i++)
                        if (pv[i] && (!have || pcnt[i] < pcnt[v] ||
                                (pcnt[i] == pcnt[v] && prank[i] > prank[v]))) begin
                            v = i; have = 1;
                        end
                    r.evicted = 1'b1;
                    r.evicted_key = pk[v];
                    pv[v] = 1'b0;
                    pocc--;
                    for (int i = 0; i < NCAP; i++)
                        if (pv[i] && prank[i] > prank[v]) prank[i]--;
                end
                fr = -1;
                for (int i = NCAP - 1; i >= 0; i--)
                    if (!pv[i]) fr = i;
                if (fr >= 0) begin
                    for (int j = 0; j < NCAP; j++)
                        if (pv[j]) prank[j]++;
                    pv[fr] = 1'b1; pk[fr] = key; pval[fr] = val;
                    pcnt[fr] = 1; prank[fr] = 0;
                    pocc++;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered item
        end else if (cfg_valid) begin
            s_tvalid <= 1'b0;
        end else if (pending_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (pending_q[0].is_cfg || pending_q[0].drain) begin
            s_tvalid <= 1'b0;
            if (expected_q.size() == 0 && !(s_tvalid && s_tready) && !m_tvalid
                    && hold_cycles == 0) begin
                if (pending_q[0].is_cfg) begin
                    cfg_valid <= 1'b1;
                    cfg_data <= pending_q[0].cap;
                    cap_r = pending_q[0].cap;
                end
                void'(pending_q.pop_front());
            end
        end else if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tuser <= pending_q[0].op;
            s_tdata <= {pending_q[0].val, pending_q[0].key};
            expected_q.push_back(predict_access(pending_q[0].op, pending_q[0].key,
                                                pending_q[0].val));
            void'(pending_q.pop_front());
        end
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // hold-off counter before config writes, so an in-flight item can finish
    always @(posedge aclk) begin
        if (expected_q.size() != 0 || m_tvalid || s_tvalid) hold_cycles <= 80;
        else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // receiver with long stall support
    int long_stall = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_req && !stall_started) begin
            stall_started <= 1'b1;
            long_stall <= 400;
            m_tready <= 1'b0;
        end else if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        lfu_ct_pkg::res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata[31:0], 32'h0);
            end else begin
                w = expected_q.pop_front();
                if (m_tuser[0] !== w.hit)
                    report_mismatch("hit", 32'(m_tuser[0]), 32'(w.hit));
                if (m_tdata[31:0] !== w.read_value)
                    report_mismatch("read_value", m_tdata[31:0], w.read_value);
                if (m_tuser[1] !== w.evicted)
                    report_mismatch("evicted", 32'(m_tuser[1]), 32'(w.evicted));
                if (m_tdata[63:32] !== w.evicted_key)
                    report_mismatch("evicted_key", m_tdata[63:32], w.evicted_key);
            end
        end
    end

    task automatic add_access(logic op, logic [31:0] key, logic [31:0] val);
        txn_t t;
        t = '0;
        t.op = op; t.key = key; t.val = val;
        pending_q.push_back(t);
        keys_used.push_back(key);
    endtask

    task automatic add_cfg(logic [4:0] c);
        txn_t t;
        t = '0;
        t.is_cfg = 1'b1; t.cap = c;
        pending_q.push_back(t);
    endtask

    task automatic add_drain();
        txn_t t;
        t = '0;
        t.drain = 1'b1;
        pending_q.push_back(t);
    endtask

    function automatic logic [31:0] pick_key(int pool);
        if (keys_used.size() > 0 && $urandom_range(99) < 70)
            return keys_used[$urandom_range(keys_used.size() - 1)] ;
        return (pool > 0) ? $urandom_range(pool) : $urandom;
    endfunction

    task automatic add_random(int n, int pool);
        for (int i = 0; i < n; i++)
            add_access(1'($urandom_range(1)), pick_key(pool), $urandom);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0 || s_tvalid || hold_cycles != 0)
            @(posedge aclk);
    endtask

    initial begin
        int wait_count;
        // directed: extremes, miss, hit, overwrite, eviction
        add_access(lfu_ct_pkg::OP_GET, 32'h8000_0000, 32'h7FFF_FFFF);
        add_access(lfu_ct_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        add_access(lfu_ct_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        add_access(lfu_ct_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
        add_access(lfu_ct_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
        add_access(lfu_ct_pkg::OP_GET, 32'h8000_0000, 32'h0);
        add_access(lfu_ct_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_access(lfu_ct_pkg::OP_PUT, 32'h0, 32'h1234_5678);
        add_access(lfu_ct_pkg::OP_GET, 32'h0, 32'h0);
        add_drain();
        add_cfg(5'd2);
        add_access(lfu_ct_pkg::OP_PUT, 32'd100, 32'd1);
        add_access(lfu_ct_pkg::OP_PUT, 32'd101, 32'd2);
        add_access(lfu_ct_pkg::OP_GET, 32'd5, 32'd0);
        add_drain();
        add_cfg(5'd0);
        add_access(lfu_ct_pkg::OP_PUT, 32'd200, 32'd3);
        add_access(lfu_ct_pkg::OP_GET, 32'h0, 32'd0);
        add_drain();
        add_cfg(5'd31);
        add_access(lfu_ct_pkg::OP_PUT, 32'd300, 32'd4);
        add_access(lfu_ct_pkg::OP_GET, 32'd300, 32'd0);

        send_idle = 7; recv_idle = 86;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        add_random(120, 40);
        add_drain();
        add_cfg(5'd1);
        add_random(40, 6);
        add_drain();
        add_cfg(5'd4);
        add_random(60, 12);
        wait_drained();

        send_idle = 86; recv_idle = 7;
        add_cfg(5'd16);
        add_random(60, 30);
        add_drain();
        add_cfg(5'd3);
        add_random(60, 10);
        wait_drained();

        send_idle = 0; recv_idle = 0;
        add_cfg(5'd17);
        add_random(80, 25);
        add_drain();
        add_cfg(5'd8);
        add_random(40, 0);
        wait_drained();
        stall_req = 1'b1;
        add_random(40, 20);
        wait_drained();

        wait_count = 0;
        while (wait_count < 200) begin
            @(posedge aclk);
            wait_count++;
        end
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/lfu_ct_pkg.sv
rtl/lfu_ct_store.sv
rtl/lfu_ct_ctrl.sv
rtl/lfu_cache_table.sv
rtl/lfu_ct_checker.sv
sim/tb_lfu_cache_table.sv
